// File: design/fixed_width_integer_alu_unit_assert.svh
// assertion macros for the integer alu
`ifndef FIXED_WIDTH_INTEGER_ALU_UNIT_ASSERT_SVH
`define FIXED_WIDTH_INTEGER_ALU_UNIT_ASSERT_SVH

// same-cycle implication
`define FWIA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwia assertion failed");

// next-cycle implication
`define FWIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fwia assertion failed");

`endif

// File: design/fwia_pkg.sv
`default_nettype none
package fwia_pkg;

   typedef struct packed {
      logic [4:0]  command;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic [63:0] modulus;
      logic [5:0]  bit_pos;
      logic [6:0]  bit_count;
      logic [2:0]  predicate;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic [63:0] second_result;
      logic        condition_true;
      logic [1:0]  status;
   } rsp_type;

   localparam logic [4:0] CMD_ADD     = 5'd0;
   localparam logic [4:0] CMD_SUB     = 5'd1;
   localparam logic [4:0] CMD_MUL     = 5'd2;
   localparam logic [4:0] CMD_DIV     = 5'd3;
   localparam logic [4:0] CMD_REM     = 5'd4;
   localparam logic [4:0] CMD_DIVMOD  = 5'd5;
   localparam logic [4:0] CMD_POW     = 5'd6;
   localparam logic [4:0] CMD_POWMOD  = 5'd7;
   localparam logic [4:0] CMD_NEG     = 5'd8;
   localparam logic [4:0] CMD_ABS     = 5'd9;
   localparam logic [4:0] CMD_NOT     = 5'd10;
   localparam logic [4:0] CMD_SHL     = 5'd11;
   localparam logic [4:0] CMD_SHR     = 5'd12;
   localparam logic [4:0] CMD_AND     = 5'd13;
   localparam logic [4:0] CMD_OR      = 5'd14;
   localparam logic [4:0] CMD_XOR     = 5'd15;
   localparam logic [4:0] CMD_ROTL    = 5'd16;
   localparam logic [4:0] CMD_ROTR    = 5'd17;
   localparam logic [4:0] CMD_EXTRACT = 5'd18;
   localparam logic [4:0] CMD_INSERT  = 5'd19;
   localparam logic [4:0] CMD_COMPARE = 5'd20;

   localparam logic [2:0] PRED_LT = 3'd0;
   localparam logic [2:0] PRED_LE = 3'd1;
   localparam logic [2:0] PRED_EQ = 3'd2;
   localparam logic [2:0] PRED_NE = 3'd3;
   localparam logic [2:0] PRED_GT = 3'd4;
   localparam logic [2:0] PRED_GE = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_ZERO_MOD = 2'd2;
   localparam logic [1:0] ST_NEG_EXP  = 2'd3;

   localparam logic CSR_WIDTH_SELECT = 1'b0;
   localparam logic CSR_SIGNED_MODE  = 1'b1;

   localparam logic [1:0] MSEL_AB = 2'd0;
   localparam logic [1:0] MSEL_RB = 2'd1;
   localparam logic [1:0] MSEL_BB = 2'd2;

   localparam logic [1:0] MDST_RES  = 2'd0;
   localparam logic [1:0] MDST_R    = 2'd1;
   localparam logic [1:0] MDST_BASE = 2'd2;

   localparam logic [1:0] DSEL_AB  = 2'd0;
   localparam logic [1:0] DSEL_POW = 2'd1;

   typedef struct packed {
      logic       load;
      logic       simple;
      logic       mul_load;
      logic [1:0] mul_sel;
      logic       mul_wr;
      logic [1:0] mul_dest;
      logic       div_load;
      logic [1:0] div_sel;
      logic       div_fin;
      logic       pow_init;
      logic       pow_fin;
      logic       exp_shift;
      logic       emit;
   } fwia_cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic is_pow;
      logic is_powmod;
      logic b_zero;
      logic b_neg;
      logic md_zero;
      logic exp_zero;
      logic exp_lsb;
      logic mul_done;
      logic div_done;
   } fwia_stat_type;

   function automatic logic [63:0] low_mask(input logic [6:0] n);
      logic [63:0] one;
      one = 64'd1;
      if (n >= 7'd64) begin
         return '1;
      end
      return (one << n[5:0]) - 64'd1;
   endfunction

   function automatic logic [63:0] ext(input logic [63:0] v, input logic [6:0] w,
                                       input logic s);
      logic [63:0] m;
      logic [6:0]  top;
      logic [63:0] r;
      m   = low_mask(w);
      top = w - 7'd1;
      r   = v & m;
      if (s && v[top[5:0]]) begin
         r = r | ~m;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/fwia_datapath.sv
`default_nettype none
module fwia_datapath #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fwia_pkg::req_type      req_item,
   input  wire fwia_pkg::fwia_cmd_type cmd,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [1:0]             csr_wdata,
   output fwia_pkg::fwia_stat_type     stat,
   output fwia_pkg::rsp_type           rsp_item
);
   import fwia_pkg::*;

   localparam logic [6:0] WIDTH_CAP = 7'(MAX_WIDTH);

   logic [1:0]  ws_ff;
   logic        sgn_ff;
   logic [4:0]  cmd_ff;
   logic [63:0] a_ff, b_ff, braw_ff, md_ff, ub_ff;
   logic [5:0]  pos_ff;
   logic [6:0]  cnt_ff;
   logic [2:0]  pred_ff;
   logic [63:0] mx_ff, my_ff, macc_ff;
   logic [63:0] pr_ff, pb_ff, pe_ff;
   logic [63:0] dq_ff, dr_ff, dd_ff;
   logic [6:0]  dcnt_ff;
   logic        dqneg_ff, drneg_ff;
   logic [63:0] res_ff, sec_ff;
   logic        cond_ff;
   logic [1:0]  st_ff;
   rsp_type     rsp_ff;

   logic [6:0]  wraw, w;
   logic [63:0] m;
   logic        a_neg, b_neg;
   logic [63:0] x, y;
   logic [63:0] s_res;
   logic        s_cond;
   logic [1:0]  s_st;
   logic [63:0] fm;
   logic [63:0] powx;
   logic [64:0] rem_t;
   logic [63:0] qs, rs;
   logic [6:0]  rot, rotn;
   logic [63:0] rot_v, rot_res;
   logic [63:0] div_x, div_y;
   logic        div_xn, div_yn;
   logic [63:0] mul_x, mul_y;

   always_comb begin
      wraw = 7'd8 << ws_ff;
      w    = (wraw > WIDTH_CAP) ? WIDTH_CAP : wraw;
      m    = low_mask(w);
      a_neg = sgn_ff & a_ff[63];
      b_neg = sgn_ff & b_ff[63];
   end

   assign stat.is_mul    = (cmd_ff == CMD_MUL);
   assign stat.is_div    = (cmd_ff == CMD_DIV) || (cmd_ff == CMD_REM) ||
                           (cmd_ff == CMD_DIVMOD);
   assign stat.is_pow    = (cmd_ff == CMD_POW) || (cmd_ff == CMD_POWMOD);
   assign stat.is_powmod = (cmd_ff == CMD_POWMOD);
   assign stat.b_zero    = (ub_ff == 64'd0);
   assign stat.b_neg     = b_neg;
   assign stat.md_zero   = ((md_ff & m) == 64'd0);
   assign stat.exp_zero  = (pe_ff == 64'd0);
   assign stat.exp_lsb   = pe_ff[0];
   assign stat.mul_done  = (my_ff == 64'd0);
   assign stat.div_done  = (dcnt_ff == 7'd0);

   // simple operations and error outcomes
   always_comb begin
      s_res  = '0;
      s_cond = 1'b0;
      s_st   = ST_OK;
      x      = a_ff ^ {sgn_ff, 63'd0};
      y      = b_ff ^ {sgn_ff, 63'd0};
      fm     = low_mask(cnt_ff) << pos_ff;
      unique case (cmd_ff)
         CMD_ADD: s_res = a_ff + b_ff;
         CMD_SUB: s_res = a_ff - b_ff;
         CMD_NEG: s_res = 64'd0 - a_ff;
         CMD_ABS: s_res = a_neg ? 64'd0 - a_ff : a_ff;
         CMD_NOT: s_res = ~a_ff;
         CMD_SHL: s_res = (ub_ff >= {57'd0, w}) ? 64'd0 : (a_ff << ub_ff[5:0]);
         CMD_SHR: begin
            if (ub_ff >= {57'd0, w}) begin
               s_res = a_neg ? '1 : 64'd0;
            end else if (a_neg) begin
               s_res = 64'($signed(a_ff) >>> ub_ff[5:0]);
            end else begin
               s_res = a_ff >> ub_ff[5:0];
            end
         end
         CMD_AND: s_res = a_ff & b_ff;
         CMD_OR:  s_res = a_ff | b_ff;
         CMD_XOR: s_res = a_ff ^ b_ff;
         CMD_ROTL, CMD_ROTR: s_res = rot_res;
         CMD_EXTRACT: begin
            if (a_neg) begin
               s_res = 64'($signed(a_ff) >>> pos_ff) & low_mask(cnt_ff);
            end else begin
               s_res = (a_ff >> pos_ff) & low_mask(cnt_ff);
            end
         end
         CMD_INSERT: s_res = a_ff ^ ((a_ff ^ (braw_ff << pos_ff)) & fm);
         CMD_COMPARE: begin
            unique case (pred_ff)
               PRED_LT: s_cond = (x < y);
               PRED_LE: s_cond = (x <= y);
               PRED_EQ: s_cond = (x == y);
               PRED_NE: s_cond = (x != y);
               PRED_GT: s_cond = (x > y);
               PRED_GE: s_cond = (x >= y);
               default: s_cond = 1'b0;
            endcase
         end
         CMD_DIV, CMD_REM, CMD_DIVMOD: s_st = ST_DIV_ZERO;
         CMD_POW, CMD_POWMOD: begin
            if (b_neg) begin
               if (cmd_ff == CMD_POWMOD) begin
                  s_st = ST_NEG_EXP;
               end else begin
                  s_res = 64'd1;
               end
            end else begin
               s_st = ST_ZERO_MOD;
            end
         end
         default: s_res = '0;
      endcase
   end

   // divider and multiplier operand selection, result sign fix-up and rotate
   always_comb begin
      powx   = ext(pr_ff, w, sgn_ff);
      div_x  = a_ff;
      div_y  = b_ff;
      div_xn = a_neg;
      div_yn = b_neg;
      mul_x  = a_ff;
      mul_y  = b_ff;
      unique case (cmd.div_sel)
         DSEL_POW: begin
            div_x  = powx;
            div_y  = md_ff;
            div_xn = sgn_ff & powx[63];
            div_yn = sgn_ff & md_ff[63];
         end
         default: begin
            div_x = a_ff;
         end
      endcase
      unique case (cmd.mul_sel)
         MSEL_RB: begin
            mul_x = pr_ff;
            mul_y = pb_ff;
         end
         MSEL_BB: begin
            mul_x = pb_ff;
            mul_y = pb_ff;
         end
         default: begin
            mul_x = a_ff;
         end
      endcase
      rem_t = {dr_ff, dq_ff[63]};
      qs    = dqneg_ff ? 64'd0 - dq_ff : dq_ff;
      rs    = drneg_ff ? 64'd0 - dr_ff : dr_ff;
      // width is a power of two, so the count modulo width is a mask
      rot   = ub_ff[6:0] & (w - 7'd1);
      rotn  = ((cmd_ff == CMD_ROTR) && (rot != 7'd0)) ? w - rot : rot;
      rot_v = a_ff & m;
      rot_res = (rotn == 7'd0) ? rot_v : ((rot_v << rotn) | (rot_v >> (w - rotn)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= 2'd3;
         sgn_ff  <= 1'b0;
         dcnt_ff <= 7'd0;
         my_ff   <= 64'd0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_WIDTH_SELECT) begin
               ws_ff <= csr_wdata;
            end else begin
               sgn_ff <= csr_wdata[0];
            end
         end
         if (my_ff != 64'd0) begin
            macc_ff <= macc_ff + (my_ff[0] ? mx_ff : 64'd0);
            mx_ff   <= mx_ff << 1;
            my_ff   <= my_ff >> 1;
         end
         if (cmd.mul_load) begin
            mx_ff   <= mul_x;
            my_ff   <= mul_y;
            macc_ff <= 64'd0;
         end
         if (dcnt_ff != 7'd0) begin
            dcnt_ff <= dcnt_ff - 7'd1;
            if (rem_t >= {1'b0, dd_ff}) begin
               dr_ff <= 64'(rem_t - {1'b0, dd_ff});
               dq_ff <= {dq_ff[62:0], 1'b1};
            end else begin
               dr_ff <= rem_t[63:0];
               dq_ff <= {dq_ff[62:0], 1'b0};
            end
         end
         if (cmd.div_load) begin
            dq_ff    <= div_xn ? 64'd0 - div_x : div_x;
            dd_ff    <= div_yn ? 64'd0 - div_y : div_y;
            dr_ff    <= 64'd0;
            dcnt_ff  <= 7'd64;
            dqneg_ff <= div_xn ^ div_yn;
            drneg_ff <= div_xn;
         end
      end
      if (cmd.load) begin
         cmd_ff  <= req_item.command;
         a_ff    <= ext(req_item.operand_a, w, sgn_ff);
         b_ff    <= ext(req_item.operand_b, w, sgn_ff);
         md_ff   <= ext(req_item.modulus, w, sgn_ff);
         ub_ff   <= req_item.operand_b & m;
         braw_ff <= req_item.operand_b;
         pos_ff  <= req_item.bit_pos;
         cnt_ff  <= (req_item.bit_count > 7'd64) ? 7'd64 : req_item.bit_count;
         pred_ff <= req_item.predicate;
      end
      if (cmd.pow_init) begin
         pr_ff <= 64'd1;
         pb_ff <= a_ff;
         pe_ff <= ub_ff;
      end
      if (cmd.exp_shift) begin
         pe_ff <= pe_ff >> 1;
      end
      if (cmd.mul_wr) begin
         unique case (cmd.mul_dest)
            MDST_R:    pr_ff <= macc_ff;
            MDST_BASE: pb_ff <= macc_ff;
            default: begin
               res_ff  <= macc_ff;
               sec_ff  <= 64'd0;
               cond_ff <= 1'b0;
               st_ff   <= ST_OK;
            end
         endcase
      end
      if (cmd.simple) begin
         res_ff  <= s_res;
         sec_ff  <= 64'd0;
         cond_ff <= s_cond;
         st_ff   <= s_st;
      end
      if (cmd.pow_fin) begin
         res_ff  <= pr_ff;
         sec_ff  <= 64'd0;
         cond_ff <= 1'b0;
         st_ff   <= ST_OK;
      end
      if (cmd.div_fin) begin
         sec_ff  <= 64'd0;
         cond_ff <= 1'b0;
         st_ff   <= ST_OK;
         if ((cmd_ff == CMD_REM) || (cmd_ff == CMD_POWMOD)) begin
            res_ff <= rs;
         end else begin
            res_ff <= qs;
            if (cmd_ff == CMD_DIVMOD) begin
               sec_ff <= rs;
            end
         end
      end
      if (cmd.emit) begin
         rsp_ff.result         <= ext(res_ff, w, sgn_ff);
         rsp_ff.second_result  <= ext(sec_ff, w, sgn_ff);
         rsp_ff.condition_true <= cond_ff;
         rsp_ff.status         <= st_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

// File: design/fwia_ctrl.sv
`default_nettype none
`include "fixed_width_integer_alu_unit_assert.svh"
module fwia_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_valid,
   input  wire fwia_pkg::fwia_stat_type stat,
   output fwia_pkg::fwia_cmd_type       cmd
);
   import fwia_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_DEC  = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_POW  = 8'b0000_1000,
      S_PMR  = 8'b0001_0000,
      S_PMB  = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (stat.is_mul) begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = MSEL_AB;
               state_in     = S_MUL;
            end else if (stat.is_div && !stat.b_zero) begin
               cmd.div_load = 1'b1;
               cmd.div_sel  = DSEL_AB;
               state_in     = S_DIV;
            end else if (stat.is_pow && !stat.b_neg &&
                         !(stat.is_powmod && stat.md_zero)) begin
               cmd.pow_init = 1'b1;
               state_in     = S_POW;
            end else begin
               cmd.simple = 1'b1;
               state_in   = S_OUT;
            end
         end
         S_MUL: begin
            if (stat.mul_done) begin
               cmd.mul_wr   = 1'b1;
               cmd.mul_dest = MDST_RES;
               state_in     = S_OUT;
            end
         end
         S_POW: begin
            if (stat.exp_zero) begin
               if (stat.is_powmod) begin
                  cmd.div_load = 1'b1;
                  cmd.div_sel  = DSEL_POW;
                  state_in     = S_DIV;
               end else begin
                  cmd.pow_fin = 1'b1;
                  state_in    = S_OUT;
               end
            end else if (stat.exp_lsb) begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = MSEL_RB;
               state_in     = S_PMR;
            end else begin
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = MSEL_BB;
               state_in     = S_PMB;
            end
         end
         S_PMR: begin
            if (stat.mul_done) begin
               cmd.mul_wr   = 1'b1;
               cmd.mul_dest = MDST_R;
               cmd.mul_load = 1'b1;
               cmd.mul_sel  = MSEL_BB;
               state_in     = S_PMB;
            end
         end
         S_PMB: begin
            if (stat.mul_done) begin
               cmd.mul_wr    = 1'b1;
               cmd.mul_dest  = MDST_BASE;
               cmd.exp_shift = 1'b1;
               state_in      = S_POW;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_fin = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_OUT);
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FWIA_ASSERT_NEXT(a_accept_decodes, clock, reset, start && !busy, state_ff == S_DEC)
   `FWIA_ASSERT_NEXT(a_out_strobes, clock, reset, state_ff == S_OUT, rsp_valid)
   `FWIA_ASSERT_NOW(a_strobe_when_idle, clock, reset, rsp_valid, state_ff != S_OUT)
   `FWIA_ASSERT_NEXT(a_div_finishes, clock, reset, state_ff == S_DIV && stat.div_done, state_ff == S_OUT)

endmodule
`default_nettype wire

// File: design/fixed_width_integer_alu_unit.sv
`default_nettype none
// integer alu, 8/16/32/64 bit, signed or unsigned
// request channel: drive req_item and raise start; the request is taken at
// a clock edge where start is high and busy is low. busy stays high until
// the result has been staged.
// result channel: rsp_valid is high for one cycle with rsp_item; there is
// no back-pressure, the result must be captured in that cycle.
// csr port: csr_we with csr_index 0 writes width_select, index 1 writes
// signed_mode; write only while busy is low and no result is pending.
// simple operations (rotate included) are computed combinationally and
// registered in the decode state; multiply is bit-serial shift-add and stops
// early on a short multiplier; divide and remainder take one quotient bit
// per cycle through the restoring divider; power takes up to two multiplies
// per exponent bit, plus one divider pass for powmod.
// one request is in flight at a time; a new request may be taken in the
// cycle its predecessor's result is shown.
// reset: width 64, unsigned mode, controller idle, no result pending.
module fixed_width_integer_alu_unit #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire fwia_pkg::req_type req_item,
   output logic                   rsp_valid,
   output fwia_pkg::rsp_type      rsp_item,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [1:0]        csr_wdata
);
   import fwia_pkg::*;

   fwia_cmd_type  cmd;
   fwia_stat_type stat;

   fwia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   fwia_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
